// ----- sv/itoa_pkg.sv -----
// itoa_pkg: widths, character codes, microcode table and control structs
// for the integer to ascii radix converter; no dependencies
package itoa_pkg;

   localparam int MAX_DIGITS  = 32;
   localparam int STACK_DEPTH = (MAX_DIGITS > 32) ? MAX_DIGITS : 32;
   localparam int ND_W        = $clog2(STACK_DEPTH + 1);
   localparam int PAD_W       = $clog2(MAX_DIGITS + 1);

   localparam int WORD_W = 32;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int DIG_W  = 6;
   localparam int CHAR_W = 7;
   localparam int PC_W   = 3;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
   localparam logic [DIG_W-1:0]  RADIX_DEC  = 6'd10;
   localparam logic [DIG_W-1:0]  RADIX_MIN  = 6'd2;
   localparam logic [DIG_W-1:0]  RADIX_MAX  = 6'd36;

   localparam logic [PC_W-1:0] STEP_LOAD = 3'd0;
   localparam logic [PC_W-1:0] STEP_DIV  = 3'd1;
   localparam logic [PC_W-1:0] STEP_PUSH = 3'd2;
   localparam logic [PC_W-1:0] STEP_SIGN = 3'd3;
   localparam logic [PC_W-1:0] STEP_POP  = 3'd4;
   localparam logic [PC_W-1:0] STEP_DONE = 3'd5;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV,
      OP_PUSH,
      OP_SIGN,
      OP_POP
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_BIT_MORE,
      COND_DIGIT_MORE,
      COND_POP_MORE
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic neg;
      logic bit_more;
      logic digit_more;
      logic pop_more;
   } sts_type;

   typedef struct packed {
      op_type op;
      logic   fire;
   } ctl_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         STEP_LOAD: w = '{op: OP_LOAD, cond: COND_NEVER,      target: STEP_LOAD};
         STEP_DIV:  w = '{op: OP_DIV,  cond: COND_BIT_MORE,   target: STEP_DIV};
         STEP_PUSH: w = '{op: OP_PUSH, cond: COND_DIGIT_MORE, target: STEP_DIV};
         STEP_SIGN: w = '{op: OP_SIGN, cond: COND_NEVER,      target: STEP_LOAD};
         STEP_POP:  w = '{op: OP_POP,  cond: COND_POP_MORE,   target: STEP_POP};
         STEP_DONE: w = '{op: OP_NOP,  cond: COND_ALWAYS,     target: STEP_LOAD};
         default:   w = '{op: OP_NOP,  cond: COND_ALWAYS,     target: STEP_LOAD};
      endcase
      return w;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < RADIX_DEC) begin
         c = CHAR_ZERO + {1'b0, d};
      end else begin
         c = CHAR_A + {1'b0, d} - {1'b0, RADIX_DEC};
      end
      return c;
   endfunction

endpackage

// ----- sv/itoa_seq.sv -----
// itoa_seq: step counter and microcode table of the converter
// depends on itoa_pkg (control word, status and control structs)
module itoa_seq (
   input  logic              clock,
   input  logic              reset,
   input  itoa_pkg::sts_type sts,
   output itoa_pkg::ctl_type ctl
);
   import itoa_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_type       word;
   logic            go;
   logic            taken;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      case (word.op)
         OP_LOAD: go = sts.req_valid;
         OP_SIGN: go = !sts.neg || sts.out_free;
         OP_POP:  go = sts.out_free;
         default: go = 1'b1;
      endcase
   end

   always_comb begin
      case (word.cond)
         COND_NEVER:      taken = 1'b0;
         COND_ALWAYS:     taken = 1'b1;
         COND_BIT_MORE:   taken = sts.bit_more;
         COND_DIGIT_MORE: taken = sts.digit_more;
         COND_POP_MORE:   taken = sts.pop_more;
         default:         taken = 1'b0;
      endcase
   end

   always_comb begin
      if (!go) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctl.op   = word.op;
   assign ctl.fire = go;

`ifndef NO_ASSERTIONS
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= STEP_DONE)
      else $error("step counter outside program");
   a_load_waits: assert property (@(posedge clock) disable iff (reset)
      (word.op == OP_LOAD && !sts.req_valid) |=> pc_ff == STEP_LOAD)
      else $error("sequencer left load without a beat");
   a_div_to_push: assert property (@(posedge clock) disable iff (reset)
      (word.op == OP_DIV && !sts.bit_more) |=> pc_ff == STEP_PUSH)
      else $error("division did not end in push");
`endif

endmodule

// ----- sv/integer_to_ascii_radix.sv -----
// integer_to_ascii_radix: top level, datapath of the radix converter
// depends on itoa_pkg and itoa_seq
//
// Converts one 32-bit value per request beat into ascii characters, most
// significant first, the final one flagged by rsp_last. A microcoded step
// counter drives a restoring divider that takes one quotient bit per cycle,
// so each digit costs 32 divide steps and a push onto the digit stack. With
// n digits an item runs through load, n digit rounds, an optional sign, one
// pop per character and one return step, and any response stall holds the
// sign and pop steps. A new request is taken only once the previous item's
// last character has entered the output register.
module integer_to_ascii_radix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [itoa_pkg::WORD_W-1:0]   req_number,
   input  logic                          req_is_signed,
   input  logic [itoa_pkg::DIG_W-1:0]    req_base,
   input  logic [itoa_pkg::DIG_W-1:0]    req_min_digits,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itoa_pkg::CHAR_W-1:0]   rsp_character,
   output logic                          rsp_last
);
   import itoa_pkg::*;

   sts_type sts;
   ctl_type ctl;

   logic [DIG_W-1:0]  radix_ff, radix_in;
   logic [PAD_W-1:0]  pad_ff, pad_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [DIG_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [ND_W-1:0]   nd_ff, nd_in;
   logic              neg_ff, neg_in;
   logic [DIG_W-1:0]  stack_ff [STACK_DEPTH];
   logic [DIG_W-1:0]  stack_in [STACK_DEPTH];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [DIG_W-1:0]  radix_clamp;
   logic              neg_load;
   logic [DIG_W:0]    trial;
   logic              qbit;
   logic [ND_W-1:0]   nd_next;
   logic              out_free;
   logic              emit;
   logic              fire_load, fire_div, fire_push, fire_sign, fire_pop;

   itoa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   assign fire_load = ctl.fire && ctl.op == OP_LOAD;
   assign fire_div  = ctl.fire && ctl.op == OP_DIV;
   assign fire_push = ctl.fire && ctl.op == OP_PUSH;
   assign fire_sign = ctl.fire && ctl.op == OP_SIGN && neg_ff;
   assign fire_pop  = ctl.fire && ctl.op == OP_POP;

   assign req_stall = reset || ctl.op != OP_LOAD;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = fire_sign || fire_pop;

   // input clamping
   always_comb begin
      if (req_base < RADIX_MIN) begin
         radix_clamp = RADIX_MIN;
      end else if (req_base > RADIX_MAX) begin
         radix_clamp = RADIX_MAX;
      end else begin
         radix_clamp = req_base;
      end
   end

   assign neg_load = req_is_signed && radix_clamp == RADIX_DEC && req_number[WORD_W-1];

   // one restoring divide step
   assign trial   = {rem_ff, quo_ff[WORD_W-1]};
   assign qbit    = trial >= {1'b0, radix_ff};
   assign nd_next = nd_ff + 1'b1;

   assign sts.req_valid  = req_valid;
   assign sts.out_free   = out_free;
   assign sts.neg        = neg_ff;
   assign sts.bit_more   = bit_ff != '0;
   assign sts.digit_more = (quo_ff != '0 || nd_next < ND_W'(pad_ff))
                           && nd_next < ND_W'(STACK_DEPTH);
   assign sts.pop_more   = nd_ff != ND_W'(1);

   always_comb begin
      radix_in = radix_ff;
      pad_in   = pad_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      nd_in    = nd_ff;
      neg_in   = neg_ff;
      stack_in = stack_ff;
      if (fire_load) begin
         radix_in = radix_clamp;
         if (int'(req_min_digits) > MAX_DIGITS) begin
            pad_in = PAD_W'(MAX_DIGITS);
         end else begin
            pad_in = PAD_W'(req_min_digits);
         end
         quo_in = neg_load ? (~req_number + 1'b1) : req_number;
         rem_in = '0;
         bit_in = BIT_W'(WORD_W - 1);
         nd_in  = '0;
         neg_in = neg_load;
      end
      if (fire_div) begin
         rem_in = qbit ? DIG_W'(trial - {1'b0, radix_ff}) : trial[DIG_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], qbit};
         bit_in = bit_ff - 1'b1;
      end
      if (fire_push) begin
         stack_in[0] = rem_ff;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
         rem_in = '0;
         bit_in = BIT_W'(WORD_W - 1);
         nd_in  = nd_next;
      end
      if (fire_pop) begin
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
         stack_in[STACK_DEPTH-1] = '0;
         nd_in = nd_ff - 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (fire_sign) begin
            rsp_char_in = CHAR_MINUS;
            rsp_last_in = 1'b0;
         end else begin
            rsp_char_in = digit_char(stack_ff[0]);
            rsp_last_in = nd_ff == ND_W'(1);
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff        <= '0;
         bit_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nd_ff        <= nd_in;
         bit_ff       <= bit_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      pad_ff      <= pad_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> nd_ff == '0)
      else $error("request beat taken with digits pending");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      fire_push |-> nd_ff < ND_W'(STACK_DEPTH))
      else $error("digit stack overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      fire_pop |-> nd_ff != '0)
      else $error("pop from empty digit stack");
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      fire_div |-> rem_ff < radix_ff)
      else $error("partial remainder not below radix");
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_last_in) |=> nd_ff == '0)
      else $error("last beat left digits on the stack");
`endif

endmodule

// ----- verif/integer_to_ascii_radix_test.sv -----
// integer_to_ascii_radix_test: self-checking bench for the radix converter,
// predicts every ascii beat per request and compares them in order
// depends on itoa_pkg and integer_to_ascii_radix
module integer_to_ascii_radix_test;
   import itoa_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } ascii_beat_type;

   localparam int DIGIT_LIMIT = 64;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [WORD_W-1:0]   req_number     = '0;
   logic                req_is_signed  = 1'b0;
   logic [DIG_W-1:0]    req_base       = '0;
   logic [DIG_W-1:0]    req_min_digits = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;

   ascii_beat_type chars_expected[$];
   int          error_count = 0;
   bit          send_gaps   = 1'b1;
   logic        stall_gaps  = 1'b1;
   int          stall_left  = 0;

   integer_to_ascii_radix i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number     (req_number),
      .req_is_signed  (req_is_signed),
      .req_base       (req_base),
      .req_min_digits (req_min_digits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // expected characters of one number, most significant first
   function automatic void predict_chars(input logic [WORD_W-1:0] number,
                                         input logic is_signed,
                                         input logic [DIG_W-1:0] base,
                                         input logic [DIG_W-1:0] min_digits);
      logic [CHAR_W-1:0] digit_stack [DIGIT_LIMIT];
      logic [WORD_W-1:0] magnitude;
      int unsigned       radix;
      int unsigned       pad;
      int unsigned       d;
      int                count;
      logic              negative;
      radix = 32'(base);
      if (radix < 32'(RADIX_MIN)) radix = 32'(RADIX_MIN);
      if (radix > 32'(RADIX_MAX)) radix = 32'(RADIX_MAX);
      pad = 32'(min_digits);
      if (pad > MAX_DIGITS) pad = MAX_DIGITS;
      if (pad > DIGIT_LIMIT) pad = DIGIT_LIMIT;
      negative  = is_signed && (radix == 32'(RADIX_DEC)) && number[WORD_W-1];
      magnitude = negative ? ({WORD_W{1'b0}} - number) : number;
      count = 0;
      do begin
         d = magnitude % radix;
         if (d < 32'(RADIX_DEC)) digit_stack[count] = CHAR_ZERO + CHAR_W'(d);
         else digit_stack[count] = CHAR_A + CHAR_W'(d - 32'(RADIX_DEC));
         count++;
         magnitude = magnitude / radix;
      end while ((magnitude != 0 || count < pad) && count < DIGIT_LIMIT);
      if (negative)
         chars_expected.push_back(ascii_beat_type'{character: CHAR_MINUS, last: 1'b0});
      for (int i = count - 1; i >= 0; i--) begin
         chars_expected.push_back(ascii_beat_type'{character: digit_stack[i],
                                                   last: (i == 0)});
      end
   endfunction

   task automatic send_number(input logic [WORD_W-1:0] number, input logic is_signed,
                              input logic [DIG_W-1:0] base, input logic [DIG_W-1:0] min_digits);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_number     <= number;
      req_is_signed  <= is_signed;
      req_base       <= base;
      req_min_digits <= min_digits;
      do @(posedge clock); while (req_stall);
      predict_chars(number, is_signed, base, min_digits);
   endtask

   // receiver stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) stall_left = stall_left - 1;
      else if (stall_gaps && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
      rsp_stall <= (stall_left > 0);
   end

   // compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      ascii_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (chars_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected beat char=%02h last=%0b",
                                      rsp_character, rsp_last));
         end else begin
            want = chars_expected.pop_front();
            if (rsp_character !== want.character)
               report_mismatch($sformatf("character %02h, want %02h",
                                         rsp_character, want.character));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
         end
      end
   end

   task automatic test_directed_cases();
      send_number(32'd0,          1'b0, 6'd10, 6'd0);
      send_number(32'd0,          1'b0, 6'd10, 6'd1);
      send_number(32'd0,          1'b1, 6'd10, 6'd0);
      send_number(32'd0,          1'b0, 6'd2,  6'd32);
      send_number(32'hffff_ffff,  1'b0, 6'd2,  6'd0);
      send_number(32'hffff_ffff,  1'b0, 6'd36, 6'd0);
      send_number(32'hffff_ffff,  1'b0, 6'd10, 6'd0);
      send_number(32'h8000_0000,  1'b1, 6'd10, 6'd0);
      send_number(32'h7fff_ffff,  1'b1, 6'd10, 6'd0);
      send_number(32'hffff_ffff,  1'b1, 6'd10, 6'd0);
      send_number(32'hffff_ff85,  1'b1, 6'd10, 6'd12);
      send_number(32'hffff_ffff,  1'b1, 6'd16, 6'd0);
      send_number(32'h8000_0000,  1'b1, 6'd2,  6'd0);
      send_number(32'd35,         1'b0, 6'd36, 6'd0);
      send_number(32'd1234567890, 1'b0, 6'd10, 6'd5);
      send_number(32'd255,        1'b0, 6'd0,  6'd0);
      send_number(32'd255,        1'b0, 6'd1,  6'd0);
      send_number(32'd255,        1'b0, 6'd37, 6'd0);
      send_number(32'hffff_ffff,  1'b1, 6'd63, 6'd63);
      send_number(32'hdead_beef,  1'b0, 6'd16, 6'd33);
      send_number(32'h89ab_cdef,  1'b0, 6'd16, 6'd8);
      send_number(32'd10,         1'b0, 6'd10, 6'd0);
      send_number(32'd7,          1'b0, 6'd8,  6'd3);
   endtask

   task automatic test_random_numbers(input int count);
      logic [WORD_W-1:0] number;
      logic [DIG_W-1:0]  base;
      logic [DIG_W-1:0]  min_digits;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            send_gaps  = ($urandom_range(0, 3) != 0);
            stall_gaps <= ($urandom_range(0, 3) != 0);
         end
         case ($urandom_range(0, 5))
            0, 1: number = $urandom;
            2:    number = $urandom_range(0, 255);
            3:    number = 32'h8000_0000 + $urandom_range(0, 3) - 2;
            4:    number = 32'hffff_ffff - $urandom_range(0, 15);
            default: number = $urandom >> $urandom_range(0, 31);
         endcase
         case ($urandom_range(0, 9))
            0:       base = 6'd10;
            1:       base = DIG_W'($urandom_range(0, 63));
            2:       base = 6'd16;
            default: base = DIG_W'($urandom_range(RADIX_MIN, RADIX_MAX));
         endcase
         case ($urandom_range(0, 9))
            0:       min_digits = DIG_W'($urandom_range(0, 63));
            1, 2:    min_digits = DIG_W'($urandom_range(0, MAX_DIGITS));
            default: min_digits = DIG_W'($urandom_range(0, 8));
         endcase
         send_number(number, 1'($urandom_range(0, 1)), base, min_digits);
      end
   endtask

   task automatic test_back_to_back(input int count);
      send_gaps  = 1'b0;
      stall_gaps <= 1'b0;
      for (int n = 0; n < count; n++) begin
         send_number($urandom, 1'($urandom_range(0, 1)),
                     DIG_W'($urandom_range(RADIX_MIN, RADIX_MAX)),
                     DIG_W'($urandom_range(0, 8)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_numbers(260);
      test_back_to_back(40);
      req_valid <= 1'b0;
      while (chars_expected.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/itoa_pkg.sv
sv/itoa_seq.sv
sv/integer_to_ascii_radix.sv
verif/integer_to_ascii_radix_test.sv
